@@ rtl/mlp_forward_backprop_trainer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the perceptron trainer
// Checks run on the rising clock edge and are held off while reset is low.
// ----------------------------------------------------------------------------
`ifndef MLP_FORWARD_BACKPROP_TRAINER_ASSERT_SVH
`define MLP_FORWARD_BACKPROP_TRAINER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MLP_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MLP_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mlp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared types, constants and fixed-point helpers for the perceptron trainer.
// ----------------------------------------------------------------------------
package mlp_pkg;

  localparam int VW     = 32;   // value width, Q16.16
  localparam int MAXW   = 16;   // neurons per layer
  localparam int WDEPTH = 816;  // 3 weight layers x 16 neurons x 17 slots
  localparam int WAW    = 10;   // weight address width
  localparam int AAW    = 6;    // activation / error term address width
  localparam int ACC_W  = 37;   // exact sum of up to 17 products
  localparam int SUM_W  = 36;   // exact sum of up to 16 squares
  localparam int CNT_W  = 5;

  localparam logic signed [VW-1:0] VMAX  = 32'sh7fff_ffff;
  localparam logic signed [VW-1:0] VMIN  = 32'sh8000_0000;
  localparam logic signed [VW-1:0] ONE_Q = 32'sh0001_0000;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_INFER  = 2'd1,
    CMD_TRAIN  = 2'd2,
    CMD_TARGET = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_OUT      = 2'd0,
    KIND_MSE      = 2'd1,
    KIND_SIZE_ERR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_INFER  = 2'd1,
    PH_TRAIN  = 2'd2,
    PH_TARGET = 2'd3
  } phase_t;

  localparam logic [2:0] REG_NUM_LAYERS = 3'd0;
  localparam logic [2:0] REG_LAYER0     = 3'd1;
  localparam logic [2:0] REG_LAYER1     = 3'd2;
  localparam logic [2:0] REG_LAYER2     = 3'd3;
  localparam logic [2:0] REG_LAYER3     = 3'd4;
  localparam logic [2:0] REG_BIAS       = 3'd5;
  localparam logic [2:0] REG_LEARN_RATE = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MWAIT,
    ST_F_RD, ST_F_MUL, ST_F_ACC, ST_F_SIG,
    ST_E_RD, ST_E_OUT,
    ST_O_RD, ST_O_SQ, ST_O_D1, ST_O_D2, ST_O_D3,
    ST_B_RD, ST_B_MUL, ST_B_ACC, ST_B_V, ST_B_D1, ST_B_D2, ST_B_D3,
    ST_U_E, ST_U_ED, ST_U_EDL, ST_U_RD, ST_U_MUL, ST_U_WR,
    ST_D_GO, ST_D_WAIT, ST_D_OUT, ST_ERR_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // saturate a wide exact sum to the value range
  function automatic logic signed [VW-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(VMAX);
    lo = ACC_W'(VMIN);
    if (x > hi) return VMAX;
    else if (x < lo) return VMIN;
    else return x[VW-1:0];
  endfunction

  // saturating difference a - b
  function automatic logic signed [VW-1:0] sub_sat(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW:0] d;
    d = {a[VW-1], a} - {b[VW-1], b};
    if (d[VW] != d[VW-1]) return d[VW] ? VMIN : VMAX;
    else return d[VW-1:0];
  endfunction

  // piecewise linear sigmoid
  function automatic logic signed [VW-1:0] sigmoid(input logic signed [VW-1:0] x);
    logic [VW-1:0] m;
    logic [16:0]   f;
    m = x[VW-1] ? VW'(-x) : x;
    if (m >= 32'd327680)      f = 17'd65536;
    else if (m >= 32'd155648) f = 17'(m >> 5) + 17'd55296;
    else if (m >= 32'd65536)  f = 17'(m >> 3) + 17'd40960;
    else                      f = 17'(m >> 2) + 17'd32768;
    if (x[VW-1]) f = 17'd65536 - f;
    return {15'd0, f};
  endfunction

  // weight slot address: layer, neuron, slot
  function automatic logic [WAW-1:0] w_addr(input logic [1:0] l, input logic [3:0] n,
                                            input logic [4:0] s);
    return WAW'(l) * 10'd272 + WAW'(n) * 10'd17 + WAW'(s);
  endfunction

  // layer size clamped to 1..MAXW
  function automatic logic [4:0] clamp_size(input logic [4:0] s);
    if (s == 5'd0) return 5'd1;
    else if (s > 5'd16) return 5'd16;
    else return s;
  endfunction

endpackage

@@ rtl/mlp_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_mul
// Two-stage Q16.16 multiplier: magnitude product, then round half away from
// zero, saturate and restore the sign; the product and the result are registered.
// ----------------------------------------------------------------------------
module mlp_mul import mlp_pkg::*; (
  input  logic                 clk,
  input  logic signed [VW-1:0] a,
  input  logic signed [VW-1:0] b,
  output logic signed [VW-1:0] res
);

  logic [VW-1:0]      ma, mb;
  logic [2*VW-1:0]    prod_r;
  logic               neg_r;
  logic [2*VW-1:0]    rnd;
  logic [47:0]        r48, lim, rc;
  logic signed [VW-1:0] res_nxt, res_r;

  // magnitudes of the operands
  assign ma = a[VW-1] ? VW'(-a) : a;
  assign mb = b[VW-1] ? VW'(-b) : b;

  // round, clip and sign
  always_comb begin
    rnd     = prod_r + 64'd32768;
    r48     = rnd[63:16];
    lim     = neg_r ? 48'h0000_8000_0000 : 48'h0000_7fff_ffff;
    rc      = (r48 > lim) ? lim : r48;
    res_nxt = neg_r ? VW'(-rc[VW-1:0]) : rc[VW-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    neg_r  <= a[VW-1] ^ b[VW-1];
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

@@ rtl/mlp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_div
// Restoring divider for the squared-error sum by the output count, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module mlp_div import mlp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [4:0]       divisor,
  output div_sts_t         sts,
  output logic [SUM_W-1:0] quot
);

  logic [SUM_W-1:0] quot_r, quot_nxt;
  logic [4:0]       rem_r, rem_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [5:0]       trial;

  // one shift-subtract step per cycle
  always_comb begin
    trial    = {rem_r, quot_r[SUM_W-1]};
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = 5'd0;
      cnt_nxt  = 6'(SUM_W);
    end else if (cnt_r != 6'd0) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt  = 5'(trial - {1'b0, divisor});
        quot_nxt = {quot_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[4:0];
        quot_nxt = {quot_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 6'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign sts.busy = (cnt_r != 6'd0);
  assign sts.done = done_r;
  assign quot     = quot_r;

endmodule

@@ rtl/mlp_forward_backprop_trainer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_forward_backprop_trainer
// Sigmoid perceptron, up to four layers of sixteen neurons, trained by
// back-propagation; weights and all vector data in synchronous memories.
// ----------------------------------------------------------------------------
// Use: weights are loaded by weight-write items on the input channel before
// any vector is sent. Inference elements, closed by in_last, start a forward
// pass whose output layer comes out as one result per neuron. Training
// elements followed by target elements start a forward pass, error terms,
// weight update and one mean squared error result; a wrong target count
// gives one size-error result and leaves the weights alone.
// Configuration is written on the cfg channel, which is always ready.
// Weight writes and non-final elements are taken back to back. A pass runs on
// one shared two-stage multiplier, and a training pass also waits for the
// error division. in_ready is low while a pass runs. Results leave through an
// output register; a stalled receiver holds the pass at its next result, and
// after the last one is loaded the block takes input again. Reset clears the
// collection phase, the pass controller and the result valid flag and loads
// the configuration defaults; the memories keep their contents.
// ----------------------------------------------------------------------------
module mlp_forward_backprop_trainer import mlp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [VW-1:0]        cfg_data,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [1:0]           in_layer_sel,
  input  logic [3:0]           in_neuron_sel,
  input  logic [4:0]           in_weight_index,
  input  logic signed [VW-1:0] in_value,
  input  logic                 in_last,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic signed [VW-1:0] out_value,
  output logic                 out_last
);

  `include "mlp_forward_backprop_trainer_assert.svh"

  // configuration registers
  logic [2:0]           num_layers_r;
  logic [4:0]           lay0_r, lay1_r, lay2_r, lay3_r;
  logic signed [VW-1:0] bias_r;
  logic [30:0]          eta_r;

  // controller
  state_t               state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0]           i_r, i_nxt;
  logic [3:0]           j_r, j_nxt;
  logic [4:0]           k_r, k_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic signed [VW-1:0] ed_r, ed_nxt;
  logic                 train_r, train_nxt;
  phase_t               phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt, len_r, len_nxt;

  // result register
  logic                 out_valid_r;
  kind_t                out_kind_r, out_kind_nxt;
  logic signed [VW-1:0] out_value_r, out_value_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_load, out_free;

  // memory ports
  logic                 w_we, w_re;
  logic [WAW-1:0]       w_wa, w_ra;
  logic signed [VW-1:0] w_wd, w_rd_r;
  logic                 a_we, a_re;
  logic [AAW-1:0]       a_wa, a_ra;
  logic signed [VW-1:0] a_wd, a_rd_r;
  logic                 e_we, e_re;
  logic [AAW-1:0]       e_wa, e_ra;
  logic signed [VW-1:0] e_wd, e_rd_r;
  logic                 t_we, t_re;
  logic [3:0]           t_wa, t_ra;
  logic signed [VW-1:0] t_wd, t_rd_r;

  logic [VW-1:0]        w_mem [WDEPTH];
  logic [VW-1:0]        a_mem [4*MAXW];
  logic [VW-1:0]        e_mem [4*MAXW];
  logic [VW-1:0]        t_mem [MAXW];

  // arithmetic units
  logic signed [VW-1:0] mul_a, mul_b, mul_res;
  logic                 div_start;
  div_sts_t             div_sts;
  logic [SUM_W-1:0]     div_quot;

  // derived sizes and operands
  logic [1:0]           top_l;
  logic [4:0]           sz_prev, sz_cur, sz_next, sz_out;
  logic signed [VW-1:0] act_x, diff, eta_s;
  logic [4:0]           c_eff, c_new;
  logic                 want_infer;

  function automatic logic [4:0] lsize(input logic [1:0] idx, input logic [4:0] s0,
                                       input logic [4:0] s1, input logic [4:0] s2,
                                       input logic [4:0] s3);
    logic [4:0] s;
    unique case (idx)
      2'd0: s = s0;
      2'd1: s = s1;
      2'd2: s = s2;
      2'd3: s = s3;
    endcase
    return clamp_size(s);
  endfunction

  mlp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  mlp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (sz_out),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  // clamp the layer count to two..four layers
  always_comb begin
    if (num_layers_r < 3'd2)      top_l = 2'd1;
    else if (num_layers_r > 3'd4) top_l = 2'd3;
    else                          top_l = 2'(num_layers_r - 3'd1);
  end

  assign sz_prev = lsize(i_r - 2'd1, lay0_r, lay1_r, lay2_r, lay3_r);
  assign sz_cur  = lsize(i_r, lay0_r, lay1_r, lay2_r, lay3_r);
  assign sz_next = lsize(i_r + 2'd1, lay0_r, lay1_r, lay2_r, lay3_r);
  assign sz_out  = lsize(top_l, lay0_r, lay1_r, lay2_r, lay3_r);

  // input layer slots beyond the collected length read as zero
  assign act_x = (i_r == 2'd1 && k_r >= len_r) ? '0 : a_rd_r;
  assign diff  = sub_sat(t_rd_r, a_rd_r);
  assign eta_s = {1'b0, eta_r};

  assign out_free   = !out_valid_r || out_ready;
  assign want_infer = (in_command == CMD_INFER);
  assign in_ready   = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;

  // next state, memory ports and datapath control
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    sum_nxt   = sum_r;
    ed_nxt    = ed_r;
    train_nxt = train_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    out_load      = 1'b0;
    out_kind_nxt  = KIND_OUT;
    out_value_nxt = a_rd_r;
    out_last_nxt  = 1'b0;
    w_we = 1'b0; w_wa = w_addr(i_r - 2'd1, j_r, k_r); w_wd = in_value;
    w_re = 1'b0; w_ra = w_addr(i_r - 2'd1, j_r, k_r);
    a_we = 1'b0; a_wa = {i_r, j_r}; a_wd = in_value;
    a_re = 1'b0; a_ra = {i_r - 2'd1, k_r[3:0]};
    e_we = 1'b0; e_wa = {i_r, j_r}; e_wd = mul_res;
    e_re = 1'b0; e_ra = {i_r, j_r};
    t_we = 1'b0; t_wa = cnt_r[3:0]; t_wd = in_value;
    t_re = 1'b0; t_ra = j_r;
    mul_a     = w_rd_r;
    mul_b     = act_x;
    div_start = 1'b0;
    c_eff     = cnt_r;
    c_new     = cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_WEIGHT: begin
              // drop writes to the input layer or past the bias slot
              if (in_layer_sel != 2'd0 && in_weight_index <= 5'd16) begin
                w_we = 1'b1;
                w_wa = w_addr(in_layer_sel - 2'd1, in_neuron_sel, in_weight_index);
              end
            end
            CMD_INFER, CMD_TRAIN: begin
              // a change of vector kind restarts collection
              if (phase_r == (want_infer ? PH_INFER : PH_TRAIN)) c_eff = cnt_r;
              else c_eff = '0;
              c_new = (c_eff <= 5'd16) ? c_eff + 5'd1 : c_eff;
              if (c_eff < 5'd16) begin
                a_we = 1'b1;
                a_wa = {2'd0, c_eff[3:0]};
              end
              if (in_last) begin
                len_nxt = c_new;
                cnt_nxt = '0;
                if (want_infer) begin
                  phase_nxt = PH_IDLE;
                  train_nxt = 1'b0;
                  i_nxt = 2'd1; j_nxt = '0; k_nxt = '0; acc_nxt = '0;
                  state_nxt = ST_F_RD;
                end else begin
                  phase_nxt = PH_TARGET;
                end
              end else begin
                cnt_nxt   = c_new;
                phase_nxt = want_infer ? PH_INFER : PH_TRAIN;
              end
            end
            CMD_TARGET: begin
              // targets count only after a complete training vector
              if (phase_r == PH_TARGET) begin
                c_new = (cnt_r <= 5'd16) ? cnt_r + 5'd1 : cnt_r;
                t_we  = (cnt_r < 5'd16);
                if (in_last) begin
                  phase_nxt = PH_IDLE;
                  cnt_nxt   = '0;
                  if (c_new != sz_out) begin
                    state_nxt = ST_ERR_OUT;
                  end else begin
                    train_nxt = 1'b1;
                    i_nxt = 2'd1; j_nxt = '0; k_nxt = '0; acc_nxt = '0;
                    state_nxt = ST_F_RD;
                  end
                end else begin
                  cnt_nxt = c_new;
                end
              end
            end
          endcase
        end
      end

      ST_MWAIT: state_nxt = ret_r;

      // forward pass: dot product over the previous layer plus bias
      ST_F_RD: begin
        w_re = 1'b1;
        a_re = 1'b1;
        state_nxt = ST_F_MUL;
      end
      ST_F_MUL: begin
        mul_a = w_rd_r;
        mul_b = (k_r == sz_prev) ? bias_r : act_x;
        ret_nxt = ST_F_ACC;
        state_nxt = ST_MWAIT;
      end
      ST_F_ACC: begin
        acc_nxt = acc_r + ACC_W'(mul_res);
        if (k_r == sz_prev) begin
          state_nxt = ST_F_SIG;
        end else begin
          k_nxt = k_r + 5'd1;
          state_nxt = ST_F_RD;
        end
      end
      ST_F_SIG: begin
        a_we = 1'b1;
        a_wa = {i_r, j_r};
        a_wd = sigmoid(sat_acc(acc_r));
        acc_nxt = '0;
        k_nxt = '0;
        if ({1'b0, j_r} == sz_cur - 5'd1) begin
          j_nxt = '0;
          if (i_r == top_l) begin
            sum_nxt = '0;
            state_nxt = train_r ? ST_O_RD : ST_E_RD;
          end else begin
            i_nxt = i_r + 2'd1;
            state_nxt = ST_F_RD;
          end
        end else begin
          j_nxt = j_r + 4'd1;
          state_nxt = ST_F_RD;
        end
      end

      // inference results, one per output neuron
      ST_E_RD: begin
        a_re = 1'b1;
        a_ra = {top_l, j_r};
        state_nxt = ST_E_OUT;
      end
      ST_E_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = KIND_OUT;
          out_value_nxt = a_rd_r;
          out_last_nxt  = ({1'b0, j_r} == sz_out - 5'd1);
          if ({1'b0, j_r} == sz_out - 5'd1) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt = j_r + 4'd1;
            state_nxt = ST_E_RD;
          end
        end
      end

      // output layer: squared error and error terms
      ST_O_RD: begin
        a_re = 1'b1;
        a_ra = {top_l, j_r};
        t_re = 1'b1;
        t_ra = j_r;
        state_nxt = ST_O_SQ;
      end
      ST_O_SQ: begin
        mul_a = diff;
        mul_b = diff;
        ret_nxt = ST_O_D1;
        state_nxt = ST_MWAIT;
      end
      ST_O_D1: begin
        sum_nxt = sum_r + SUM_W'($unsigned(mul_res));
        mul_a = a_rd_r;
        mul_b = sub_sat(ONE_Q, a_rd_r);
        ret_nxt = ST_O_D2;
        state_nxt = ST_MWAIT;
      end
      ST_O_D2: begin
        mul_a = mul_res;
        mul_b = diff;
        ret_nxt = ST_O_D3;
        state_nxt = ST_MWAIT;
      end
      ST_O_D3: begin
        e_we = 1'b1;
        e_wa = {top_l, j_r};
        if ({1'b0, j_r} == sz_out - 5'd1) begin
          j_nxt = '0;
          k_nxt = '0;
          acc_nxt = '0;
          if (top_l == 2'd1) begin
            i_nxt = 2'd1;
            state_nxt = ST_U_E;
          end else begin
            i_nxt = top_l - 2'd1;
            state_nxt = ST_B_RD;
          end
        end else begin
          j_nxt = j_r + 4'd1;
          state_nxt = ST_O_RD;
        end
      end

      // hidden layers: weighted sum of the next layer's error terms
      ST_B_RD: begin
        w_re = 1'b1;
        w_ra = w_addr(i_r, k_r[3:0], {1'b0, j_r});
        e_re = 1'b1;
        e_ra = {i_r + 2'd1, k_r[3:0]};
        state_nxt = ST_B_MUL;
      end
      ST_B_MUL: begin
        mul_a = w_rd_r;
        mul_b = e_rd_r;
        ret_nxt = ST_B_ACC;
        state_nxt = ST_MWAIT;
      end
      ST_B_ACC: begin
        acc_nxt = acc_r + ACC_W'(mul_res);
        if (k_r == sz_next - 5'd1) begin
          state_nxt = ST_B_V;
        end else begin
          k_nxt = k_r + 5'd1;
          state_nxt = ST_B_RD;
        end
      end
      ST_B_V: begin
        a_re = 1'b1;
        a_ra = {i_r, j_r};
        state_nxt = ST_B_D1;
      end
      ST_B_D1: begin
        mul_a = a_rd_r;
        mul_b = sub_sat(ONE_Q, a_rd_r);
        ret_nxt = ST_B_D2;
        state_nxt = ST_MWAIT;
      end
      ST_B_D2: begin
        mul_a = mul_res;
        mul_b = sat_acc(acc_r);
        ret_nxt = ST_B_D3;
        state_nxt = ST_MWAIT;
      end
      ST_B_D3: begin
        e_we = 1'b1;
        e_wa = {i_r, j_r};
        acc_nxt = '0;
        k_nxt = '0;
        if ({1'b0, j_r} == sz_cur - 5'd1) begin
          j_nxt = '0;
          if (i_r == 2'd1) begin
            state_nxt = ST_U_E;
          end else begin
            i_nxt = i_r - 2'd1;
            state_nxt = ST_B_RD;
          end
        end else begin
          j_nxt = j_r + 4'd1;
          state_nxt = ST_B_RD;
        end
      end

      // weight update: w += (eta * d) * input, bias slot takes the bias
      ST_U_E: begin
        e_re = 1'b1;
        e_ra = {i_r, j_r};
        state_nxt = ST_U_ED;
      end
      ST_U_ED: begin
        mul_a = eta_s;
        mul_b = e_rd_r;
        ret_nxt = ST_U_EDL;
        state_nxt = ST_MWAIT;
      end
      ST_U_EDL: begin
        ed_nxt = mul_res;
        k_nxt = '0;
        state_nxt = ST_U_RD;
      end
      ST_U_RD: begin
        w_re = 1'b1;
        a_re = 1'b1;
        state_nxt = ST_U_MUL;
      end
      ST_U_MUL: begin
        mul_a = ed_r;
        mul_b = (k_r == sz_prev) ? bias_r : act_x;
        ret_nxt = ST_U_WR;
        state_nxt = ST_MWAIT;
      end
      ST_U_WR: begin
        w_we = 1'b1;
        w_wa = w_addr(i_r - 2'd1, j_r, k_r);
        w_wd = sat_acc(ACC_W'(w_rd_r) + ACC_W'(mul_res));
        if (k_r == sz_prev) begin
          k_nxt = '0;
          if ({1'b0, j_r} == sz_cur - 5'd1) begin
            j_nxt = '0;
            if (i_r == top_l) begin
              state_nxt = ST_D_GO;
            end else begin
              i_nxt = i_r + 2'd1;
              state_nxt = ST_U_E;
            end
          end else begin
            j_nxt = j_r + 4'd1;
            state_nxt = ST_U_E;
          end
        end else begin
          k_nxt = k_r + 5'd1;
          state_nxt = ST_U_RD;
        end
      end

      // mean squared error: divide by the output count and saturate
      ST_D_GO: begin
        div_start = 1'b1;
        state_nxt = ST_D_WAIT;
      end
      ST_D_WAIT: begin
        if (div_sts.done) state_nxt = ST_D_OUT;
      end
      ST_D_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = KIND_MSE;
          out_value_nxt = (div_quot[SUM_W-1:VW-1] != '0) ? VMAX : div_quot[VW-1:0];
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_ERR_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = KIND_SIZE_ERR;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ret_r        <= ST_IDLE;
      phase_r      <= PH_IDLE;
      cnt_r        <= '0;
      len_r        <= '0;
      train_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      num_layers_r <= 3'd3;
      lay0_r       <= 5'd16;
      lay1_r       <= 5'd16;
      lay2_r       <= 5'd16;
      lay3_r       <= 5'd16;
      bias_r       <= 32'sh0001_0000;
      eta_r        <= 31'd6554;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      train_r <= train_nxt;
      // hold a result until its transfer
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_NUM_LAYERS: num_layers_r <= cfg_data[2:0];
          REG_LAYER0:     lay0_r       <= cfg_data[4:0];
          REG_LAYER1:     lay1_r       <= cfg_data[4:0];
          REG_LAYER2:     lay2_r       <= cfg_data[4:0];
          REG_LAYER3:     lay3_r       <= cfg_data[4:0];
          REG_BIAS:       bias_r       <= cfg_data;
          REG_LEARN_RATE: eta_r        <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  // loop counters, accumulators and result payload
  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    acc_r <= acc_nxt;
    sum_r <= sum_nxt;
    ed_r  <= ed_nxt;
    if (out_load) begin
      out_kind_r  <= out_kind_nxt;
      out_value_r <= out_value_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // weight memory
  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_wa] <= w_wd;
    if (w_re) w_rd_r <= w_mem[w_ra];
  end

  // activation memory
  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_wa] <= a_wd;
    if (a_re) a_rd_r <= a_mem[a_ra];
  end

  // error term memory
  always_ff @(posedge clk) begin
    if (e_we) e_mem[e_wa] <= e_wd;
    if (e_re) e_rd_r <= e_mem[e_ra];
  end

  // target memory
  always_ff @(posedge clk) begin
    if (t_we) t_mem[t_wa] <= t_wd;
    if (t_re) t_rd_r <= t_mem[t_ra];
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  `MLP_AST_NOW(a_load_free, out_load, (!out_valid_r || out_ready), "result overwritten")
  `MLP_AST_NOW(a_div_state, div_sts.done, (state_r == ST_D_WAIT), "stray divider finish")
  `MLP_AST_NOW(a_cnt_range, 1'b1, (cnt_r <= 5'd17), "element count out of range")
  `MLP_AST_NEXT(a_pass_busy, (in_valid && in_ready && in_command == CMD_INFER && in_last), !in_ready, "input taken during pass")

endmodule
